@@ sv/drdd_pkg.sv @@
// Shared widths, reset values, divider handshake types and segment table for the display driver.
package drdd_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 12;
   localparam int LEVEL_BITS          = 12;
   localparam int DIVIDEND_BITS       = 2 * LEVEL_BITS;
   localparam int DUTY_BITS           = 8;
   localparam int NUMBER_BITS         = 10;
   localparam int DIGIT_BITS          = 4;
   localparam int CSR_INDEX_BITS      = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLAMP_LOW  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLAMP_HIGH = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOLD       = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BAR_FS     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPK_FS     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MTR_FS     = 3'd5;

   localparam logic [LEVEL_BITS-1:0]  LEVEL_MAX  = 12'd4095;
   localparam logic [NUMBER_BITS-1:0] NUMBER_MAX = 10'd999;

   localparam logic [LEVEL_BITS-1:0] CLAMP_LOW_RESET  = 12'd2036;
   localparam logic [LEVEL_BITS-1:0] CLAMP_HIGH_RESET = 12'd2654;
   localparam logic [DUTY_BITS-1:0]  HOLD_RESET       = 8'd25;
   localparam logic [DUTY_BITS-1:0]  BAR_FS_RESET     = 8'd90;
   localparam logic [DUTY_BITS-1:0]  SPEAKER_FS_RESET = 8'd50;
   localparam logic [DUTY_BITS-1:0]  METER_FS_RESET   = 8'd255;

   typedef struct packed {
      logic                     start;
      logic [DIVIDEND_BITS-1:0] dividend;
      logic [LEVEL_BITS-1:0]    divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [LEVEL_BITS-1:0] quotient;
      logic [LEVEL_BITS-1:0] remainder;
   } div_rsp_type;

   // active-low segment byte; codes above nine show as nine
   function automatic logic [7:0] seg_pattern(input logic [DIGIT_BITS-1:0] digit);
      logic [7:0] seg;
      case (digit)
         4'd0:    seg = 8'hBE;
         4'd1:    seg = 8'h82;
         4'd2:    seg = 8'hEC;
         4'd3:    seg = 8'hE6;
         4'd4:    seg = 8'hD2;
         4'd5:    seg = 8'h76;
         4'd6:    seg = 8'h7E;
         4'd7:    seg = 8'hA2;
         4'd8:    seg = 8'hFE;
         default: seg = 8'hF6;
      endcase
      return ~seg;
   endfunction

endpackage

@@ sv/detector_reading_display_driver.sv @@
// Detector reading display driver top level. Each sample beat is clamped between clamp_low
// and clamp_high, inverted and rescaled to a 12-bit level, which then sets the bar, speaker
// and meter duties and, once every hold_count+1 samples, the three-digit number on the
// display; every result beat carries the lit digit and its active-low segment byte, the
// digit advancing hundreds, tens, units. One sample is worked on at a time: each scaling
// and each digit extraction is a pass through the shared bit-serial divider (four to
// seven passes), a skipped pass still takes its setup step, the result is handed to the
// output register and the next sample is taken. A finished result waits in the output
// register while the next sample is taken.
module detector_reading_display_driver #(
   parameter int SAMPLE_BITS = drdd_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [SAMPLE_BITS-1:0]              req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [drdd_pkg::LEVEL_BITS-1:0]     rsp_level,
   output logic [drdd_pkg::DUTY_BITS-1:0]      rsp_bar_duty,
   output logic [drdd_pkg::DUTY_BITS-1:0]      rsp_speaker_duty,
   output logic [drdd_pkg::DUTY_BITS-1:0]      rsp_meter_duty,
   output logic [1:0]                          rsp_digit_select,
   output logic [7:0]                          rsp_segment_pattern,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [drdd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [drdd_pkg::LEVEL_BITS-1:0]     csr_wdata
);

   localparam int LW    = drdd_pkg::LEVEL_BITS;
   localparam int DW    = drdd_pkg::DUTY_BITS;
   localparam int NW    = drdd_pkg::NUMBER_BITS;
   localparam int GW    = drdd_pkg::DIGIT_BITS;
   localparam int CMP_W = (SAMPLE_BITS > LW) ? SAMPLE_BITS : LW;
   localparam int PW    = LW + NW;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SETUP = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   localparam logic [2:0] OP_LEVEL = 3'd0;
   localparam logic [2:0] OP_BAR   = 3'd1;
   localparam logic [2:0] OP_SPK   = 3'd2;
   localparam logic [2:0] OP_MTR   = 3'd3;
   localparam logic [2:0] OP_NUM   = 3'd4;
   localparam logic [2:0] OP_DIGA  = 3'd5;
   localparam logic [2:0] OP_DIGB  = 3'd6;

   localparam logic [1:0] PTR_HUNDREDS = 2'd0;
   localparam logic [1:0] PTR_TENS     = 2'd1;
   localparam logic [1:0] PTR_UNITS    = 2'd2;

   localparam logic [LW-1:0] HUNDRED = LW'(100);
   localparam logic [LW-1:0] TEN     = LW'(10);

   logic [1:0]             state_ff, state_in;
   logic [2:0]             op_ff, op_in;
   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [LW-1:0]          clamp_low_ff, clamp_low_in;
   logic [LW-1:0]          clamp_high_ff, clamp_high_in;
   logic [DW-1:0]          hold_count_ff, hold_count_in;
   logic [DW-1:0]          bar_fs_ff, bar_fs_in;
   logic [DW-1:0]          spk_fs_ff, spk_fs_in;
   logic [DW-1:0]          mtr_fs_ff, mtr_fs_in;
   logic [DW-1:0]          hold_ff, hold_in;
   logic [NW-1:0]          shown_ff, shown_in;
   logic [1:0]             ptr_ff, ptr_in;
   logic [LW-1:0]          level_ff, level_in;
   logic [DW-1:0]          bar_ff, bar_in;
   logic [DW-1:0]          spk_ff, spk_in;
   logic [DW-1:0]          mtr_ff, mtr_in;
   logic [GW-1:0]          digit_ff, digit_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [LW-1:0]          rsp_level_ff, rsp_level_in;
   logic [DW-1:0]          rsp_bar_ff, rsp_bar_in;
   logic [DW-1:0]          rsp_spk_ff, rsp_spk_in;
   logic [DW-1:0]          rsp_mtr_ff, rsp_mtr_in;
   logic [1:0]             rsp_sel_ff, rsp_sel_in;
   logic [7:0]             rsp_seg_ff, rsp_seg_in;

   drdd_pkg::div_req_type div_req;
   drdd_pkg::div_rsp_type div_rsp;

   logic [CMP_W-1:0]                   s_ext, lo_ext, hi_ext, offset;
   logic [LW-1:0]                      offset_lo, span;
   logic [drdd_pkg::DIVIDEND_BITS-1:0] level_dividend;
   logic [NW-1:0]                      mul_b;
   logic [PW-1:0]                      product;
   logic [DW-1:0]                      duty_q;
   logic                               out_free;
   logic                               load_out;

   assign s_ext          = CMP_W'(sample_ff);
   assign lo_ext         = CMP_W'(clamp_low_ff);
   assign hi_ext         = CMP_W'(clamp_high_ff);
   assign offset         = s_ext - lo_ext;
   assign offset_lo      = offset[LW-1:0];
   assign span           = clamp_high_ff - clamp_low_ff;
   assign level_dividend = {offset_lo, {LW{1'b0}}} - {{LW{1'b0}}, offset_lo};
   assign duty_q         = div_rsp.quotient[DW-1:0];

   always_comb begin
      case (op_ff)
         OP_BAR:  mul_b = NW'(bar_fs_ff);
         OP_SPK:  mul_b = NW'(spk_fs_ff);
         OP_MTR:  mul_b = NW'(mtr_fs_ff);
         default: mul_b = drdd_pkg::NUMBER_MAX;
      endcase
   end

   assign product = PW'(level_ff) * PW'(mul_b);

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load_out = (state_ff == ST_DONE) && out_free;

   drdd_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      sample_in     = sample_ff;
      clamp_low_in  = clamp_low_ff;
      clamp_high_in = clamp_high_ff;
      hold_count_in = hold_count_ff;
      bar_fs_in     = bar_fs_ff;
      spk_fs_in     = spk_fs_ff;
      mtr_fs_in     = mtr_fs_ff;
      hold_in       = hold_ff;
      shown_in      = shown_ff;
      ptr_in        = ptr_ff;
      level_in      = level_ff;
      bar_in        = bar_ff;
      spk_in        = spk_ff;
      mtr_in        = mtr_ff;
      digit_in      = digit_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_level_in  = rsp_level_ff;
      rsp_bar_in    = rsp_bar_ff;
      rsp_spk_in    = rsp_spk_ff;
      rsp_mtr_in    = rsp_mtr_ff;
      rsp_sel_in    = rsp_sel_ff;
      rsp_seg_in    = rsp_seg_ff;

      div_req.start    = 1'b0;
      div_req.dividend = drdd_pkg::DIVIDEND_BITS'(product);
      div_req.divisor  = drdd_pkg::LEVEL_MAX;

      if (csr_valid) begin
         case (csr_index)
            drdd_pkg::CSR_CLAMP_LOW:  clamp_low_in  = csr_wdata;
            drdd_pkg::CSR_CLAMP_HIGH: clamp_high_in = csr_wdata;
            drdd_pkg::CSR_HOLD:       hold_count_in = csr_wdata[DW-1:0];
            drdd_pkg::CSR_BAR_FS:     bar_fs_in     = csr_wdata[DW-1:0];
            drdd_pkg::CSR_SPK_FS:     spk_fs_in     = csr_wdata[DW-1:0];
            drdd_pkg::CSR_MTR_FS:     mtr_fs_in     = csr_wdata[DW-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sample_in = req_sample;
               op_in     = OP_LEVEL;
               state_in  = ST_SETUP;
            end
         end
         ST_SETUP: begin
            case (op_ff)
               OP_LEVEL: begin
                  if (s_ext < lo_ext) begin
                     level_in = drdd_pkg::LEVEL_MAX;
                     op_in    = OP_BAR;
                  end else if (s_ext > hi_ext) begin
                     level_in = '0;
                     op_in    = OP_BAR;
                  end else if (span == '0) begin
                     level_in = drdd_pkg::LEVEL_MAX;
                     op_in    = OP_BAR;
                  end else begin
                     div_req.start    = 1'b1;
                     div_req.dividend = level_dividend;
                     div_req.divisor  = span;
                     state_in         = ST_WAIT;
                  end
               end
               OP_BAR, OP_SPK, OP_MTR: begin
                  div_req.start = 1'b1;
                  state_in      = ST_WAIT;
               end
               OP_NUM: begin
                  if (hold_ff == '0) begin
                     hold_in       = hold_count_ff;
                     div_req.start = 1'b1;
                     state_in      = ST_WAIT;
                  end else begin
                     hold_in = hold_ff - 1'b1;
                     op_in   = OP_DIGA;
                  end
               end
               OP_DIGA: begin
                  div_req.start    = 1'b1;
                  div_req.dividend = drdd_pkg::DIVIDEND_BITS'(shown_ff);
                  div_req.divisor  = (ptr_ff == PTR_HUNDREDS) ? HUNDRED : TEN;
                  state_in         = ST_WAIT;
               end
               default: begin
                  div_req.start    = 1'b1;
                  div_req.dividend = drdd_pkg::DIVIDEND_BITS'(div_rsp.quotient);
                  div_req.divisor  = TEN;
                  state_in         = ST_WAIT;
               end
            endcase
         end
         ST_WAIT: begin
            if (div_rsp.done) begin
               state_in = ST_SETUP;
               op_in    = op_ff + 1'b1;
               case (op_ff)
                  OP_LEVEL: level_in = drdd_pkg::LEVEL_MAX - div_rsp.quotient;
                  OP_BAR:   bar_in   = bar_fs_ff - duty_q;
                  OP_SPK:   spk_in   = spk_fs_ff - duty_q;
                  OP_MTR:   mtr_in   = mtr_fs_ff - duty_q;
                  OP_NUM:   shown_in = drdd_pkg::NUMBER_MAX - div_rsp.quotient[NW-1:0];
                  OP_DIGA: begin
                     if (ptr_ff != PTR_TENS) begin
                        state_in = ST_DONE;
                        digit_in = (ptr_ff == PTR_HUNDREDS) ? div_rsp.quotient[GW-1:0]
                                                            : div_rsp.remainder[GW-1:0];
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                     digit_in = div_rsp.remainder[GW-1:0];
                  end
               endcase
            end
         end
         default: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_level_in = level_ff;
               rsp_bar_in   = bar_ff;
               rsp_spk_in   = spk_ff;
               rsp_mtr_in   = mtr_ff;
               rsp_seg_in   = drdd_pkg::seg_pattern(digit_ff);
               case (ptr_ff)
                  PTR_HUNDREDS: begin
                     rsp_sel_in = PTR_HUNDREDS;
                     ptr_in     = PTR_TENS;
                  end
                  PTR_TENS: begin
                     rsp_sel_in = PTR_TENS;
                     ptr_in     = PTR_UNITS;
                  end
                  default: begin
                     rsp_sel_in = PTR_UNITS;
                     ptr_in     = PTR_HUNDREDS;
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         op_ff         <= OP_LEVEL;
         clamp_low_ff  <= drdd_pkg::CLAMP_LOW_RESET;
         clamp_high_ff <= drdd_pkg::CLAMP_HIGH_RESET;
         hold_count_ff <= drdd_pkg::HOLD_RESET;
         bar_fs_ff     <= drdd_pkg::BAR_FS_RESET;
         spk_fs_ff     <= drdd_pkg::SPEAKER_FS_RESET;
         mtr_fs_ff     <= drdd_pkg::METER_FS_RESET;
         hold_ff       <= '0;
         shown_ff      <= '0;
         ptr_ff        <= PTR_HUNDREDS;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         clamp_low_ff  <= clamp_low_in;
         clamp_high_ff <= clamp_high_in;
         hold_count_ff <= hold_count_in;
         bar_fs_ff     <= bar_fs_in;
         spk_fs_ff     <= spk_fs_in;
         mtr_fs_ff     <= mtr_fs_in;
         hold_ff       <= hold_in;
         shown_ff      <= shown_in;
         ptr_ff        <= ptr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      level_ff     <= level_in;
      bar_ff       <= bar_in;
      spk_ff       <= spk_in;
      mtr_ff       <= mtr_in;
      digit_ff     <= digit_in;
      rsp_level_ff <= rsp_level_in;
      rsp_bar_ff   <= rsp_bar_in;
      rsp_spk_ff   <= rsp_spk_in;
      rsp_mtr_ff   <= rsp_mtr_in;
      rsp_sel_ff   <= rsp_sel_in;
      rsp_seg_ff   <= rsp_seg_in;
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_level           = rsp_level_ff;
   assign rsp_bar_duty        = rsp_bar_ff;
   assign rsp_speaker_duty    = rsp_spk_ff;
   assign rsp_meter_duty      = rsp_mtr_ff;
   assign rsp_digit_select    = rsp_sel_ff;
   assign rsp_segment_pattern = rsp_seg_ff;

   assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_WAIT))
      else $error("divider finished outside a wait");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_SETUP && op_ff == OP_LEVEL))
      else $error("accepted sample did not start the level pass");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result beat raised without a finished sample");

   assert property (@(posedge clock) disable iff (reset)
      (ptr_ff != 2'd3) && (shown_ff <= drdd_pkg::NUMBER_MAX))
      else $error("digit pointer or shown number out of range");

   assert property (@(posedge clock) disable iff (reset)
      load_out |=> (ptr_ff != $past(ptr_ff)))
      else $error("digit pointer did not advance with a result");

endmodule

@@ sv/drdd_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle, shared by all scalings and digit extractions.
module drdd_div (
   input  logic                      clock,
   input  logic                      reset,
   input  drdd_pkg::div_req_type     req,
   output drdd_pkg::div_rsp_type     rsp
);

   localparam int W       = drdd_pkg::LEVEL_BITS;
   localparam int CNT_W   = $clog2(W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(W - 1);

   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     quo_ff, quo_in;
   logic [W-1:0]     dvs_ff, dvs_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [W:0] trial;
   logic [W:0] trial_diff;
   logic       fits;

   assign trial      = {rem_ff, quo_ff[W-1]};
   assign trial_diff = trial - {1'b0, dvs_ff};
   assign fits       = trial >= {1'b0, dvs_ff};

   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (req.start) begin
         rem_in   = req.dividend[2*W-1:W];
         quo_in   = req.dividend[W-1:0];
         dvs_in   = req.divisor;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = fits ? trial_diff[W-1:0] : trial[W-1:0];
         quo_in   = {quo_ff[W-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule
